[src/assert_macros.svh]
// Assertion macros shared by the renderer RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at each rising edge, ignored while reset is high
`define TSG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property at each rising edge, reset included
`define TSG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSG_ASSERT(lbl, clk, rst, prop, msg)
`define TSG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[src/tsg_pkg.sv]
// Types and constants of the text/semigraphics line renderer.
// No dependencies; imported by every renderer module except tsg_ram.
`default_nettype none

package tsg_pkg;

   // Operation codes of an input word
   localparam logic [1:0] OP_VIDEO  = 2'd0;
   localparam logic [1:0] OP_FONT   = 2'd1;
   localparam logic [1:0] OP_RENDER = 2'd2;

   // Command kinds handed from the front end to the back end
   localparam logic [1:0] CMD_VIDEO  = 2'd0;
   localparam logic [1:0] CMD_FONT   = 2'd1;
   localparam logic [1:0] CMD_BORDER = 2'd2;
   localparam logic [1:0] CMD_TEXT   = 2'd3;

   // Pixel pair codes
   localparam logic [3:0] CODE_BLACK = 4'd0;
   localparam logic [3:0] CODE_BG    = 4'd1;
   localparam logic [3:0] CODE_FG    = 4'd2;
   localparam logic       SEMI_FLAG  = 1'b1;

   // Geometry
   localparam int GLYPH_COUNT = 96;
   localparam int GLYPH_ROWS  = 12;
   localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
   localparam int FONT_AW     = $clog2(FONT_DEPTH);
   localparam logic [8:0] HALF_LINES = 9'd240;
   localparam logic [5:0] MAX_COLUMNS = 6'd40;
   localparam logic [4:0] MAX_ROWS    = 5'd20;
   localparam logic [7:0] FIRST_GLYPH = 8'd32;
   localparam logic [3:0] UPPER_ROWS  = 4'd6;

   // Reciprocal of 24 in 16 fractional bits, exact for values below 480
   localparam logic [11:0] RECIP_24 = 12'd2731;

   typedef struct packed {
      logic [1:0]  kind;
      logic [10:0] address;
      logic [7:0]  data;
      logic [9:0]  base;
      logic [3:0]  glyph_row;
      logic [5:0]  ncols;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } qstat_type;

   typedef struct packed {
      logic [7:0][3:0] pair;
      logic            is_border;
      logic            last;
   } rsp_type;

endpackage

`default_nettype wire

[src/tsg_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module tsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire  logic                     clock,
   input  wire  logic                     wr_en,
   input  wire  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  logic [WIDTH-1:0]         wr_data,
   input  wire  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic       [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read; the read data is registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/tsg_front.sv]
// Front end: accepts input words, screens writes and works out line geometry.
// Depends on tsg_pkg; feeds tsg_queue.
`default_nettype none

module tsg_front #(
   parameter int VIDEO_DEPTH = 1024
) (
   input  wire  logic              clock,
   input  wire  logic              reset,
   input  wire  logic              start,
   input  wire  logic              block,
   output logic                    busy,
   input  wire  logic [1:0]        operation,
   input  wire  logic [10:0]       address,
   input  wire  logic [7:0]        write_data,
   input  wire  logic [8:0]        line_number,
   input  wire  logic [5:0]        columns,
   input  wire  logic [4:0]        rows,
   input  wire  tsg_pkg::qstat_type qstat,
   output logic                    push,
   output tsg_pkg::cmd_type        cmd
);
   import tsg_pkg::*;

   logic        accept;
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_op_ff;
   logic [10:0] s1_addr_ff;
   logic [7:0]  s1_data_ff;
   logic [8:0]  s1_line_ff;

   logic        s2_valid_ff, s2_valid_in;
   logic        s2_keep_ff, s2_keep_in;
   logic [1:0]  s2_kind_ff, s2_kind_in;
   logic [10:0] s2_addr_ff;
   logic [7:0]  s2_data_ff;
   logic [8:0]  s2_rel_ff, s2_rel_in;
   logic [4:0]  s2_q_ff, s2_q_in;
   logic [5:0]  s2_ncols_ff, s2_ncols_in;

   logic [4:0]  nrows;
   logic [8:0]  rows_x12;
   logic [8:0]  top_line;
   logic [8:0]  end_line;
   logic        border;
   logic [20:0] q_prod;
   logic [8:0]  rem;

   // One word in the front end at a time
   assign busy   = block || s1_valid_ff || s2_valid_ff;
   assign accept = start && !busy;

   assign s1_valid_in = accept;

   // Clamp the screen size and find the border band
   always_comb begin
      s2_ncols_in = columns;
      if (columns == 6'd0) begin
         s2_ncols_in = 6'd1;
      end else if (columns > MAX_COLUMNS) begin
         s2_ncols_in = MAX_COLUMNS;
      end
      nrows = (rows > MAX_ROWS) ? MAX_ROWS : rows;
   end

   assign rows_x12  = {nrows, 3'b000} + {2'b00, nrows, 2'b00};
   assign top_line  = HALF_LINES - rows_x12;
   assign end_line  = HALF_LINES + rows_x12;
   assign border    = (s1_line_ff < top_line) || (s1_line_ff >= end_line);
   assign s2_rel_in = s1_line_ff - top_line;
   assign q_prod    = 21'(s2_rel_in) * 21'(RECIP_24);
   assign s2_q_in   = q_prod[20:16];

   // Classify the word; drop unused codes and writes out of range
   always_comb begin
      s2_kind_in = CMD_VIDEO;
      s2_keep_in = 1'b0;
      unique case (s1_op_ff)
         OP_VIDEO: begin
            s2_kind_in = CMD_VIDEO;
            s2_keep_in = 13'(s1_addr_ff) < 13'(VIDEO_DEPTH);
         end
         OP_FONT: begin
            s2_kind_in = CMD_FONT;
            s2_keep_in = 13'(s1_addr_ff) < 13'(FONT_DEPTH);
         end
         OP_RENDER: begin
            s2_kind_in = border ? CMD_BORDER : CMD_TEXT;
            s2_keep_in = 1'b1;
         end
         default: begin
            s2_kind_in = CMD_VIDEO;
            s2_keep_in = 1'b0;
         end
      endcase
   end

   // Hold stage two until the queue has room
   assign push = s2_valid_ff && s2_keep_ff && !qstat.full;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s1_valid_ff) begin
         s2_valid_in = 1'b1;
      end else if (s2_valid_ff && (!s2_keep_ff || !qstat.full)) begin
         s2_valid_in = 1'b0;
      end
   end

   // Cell row remainder and first video cell of the text row
   assign rem = s2_rel_ff - 9'(9'(s2_q_ff) * 9'd24);

   always_comb begin
      cmd.kind      = s2_kind_ff;
      cmd.address   = s2_addr_ff;
      cmd.data      = s2_data_ff;
      cmd.base      = 10'(10'(s2_q_ff) * 10'(s2_ncols_ff));
      cmd.glyph_row = rem[4:1];
      cmd.ncols     = s2_ncols_ff;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= operation;
         s1_addr_ff <= address;
         s1_data_ff <= write_data;
         s1_line_ff <= line_number;
      end
      if (s1_valid_ff) begin
         s2_keep_ff  <= s2_keep_in;
         s2_kind_ff  <= s2_kind_in;
         s2_addr_ff  <= s1_addr_ff;
         s2_data_ff  <= s1_data_ff;
         s2_rel_ff   <= s2_rel_in;
         s2_q_ff     <= s2_q_in;
         s2_ncols_ff <= s2_ncols_in;
      end
   end

endmodule

`default_nettype wire

[src/tsg_queue.sv]
// Two-entry command queue between the front end and the back end.
// Depends on tsg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tsg_queue (
   input  wire  logic              clock,
   input  wire  logic              reset,
   input  wire  logic              push,
   input  wire  tsg_pkg::cmd_type  push_cmd,
   input  wire  logic              pop,
   output tsg_pkg::cmd_type        head,
   output tsg_pkg::qstat_type      qstat
);
   import tsg_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign qstat.full      = (count_ff == 2'd2);
   assign qstat.not_empty = (count_ff != 2'd0);
   assign head            = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `TSG_ASSERT(a_push_room, clock, reset, push |-> count_ff != 2'd2, "push into full queue")
   `TSG_ASSERT(a_pop_data, clock, reset, pop |-> count_ff != 2'd0, "pop from empty queue")
   `TSG_ASSERT(a_count_range, clock, reset, count_ff != 2'd3, "queue count out of range")

endmodule

`default_nettype wire

[src/tsg_back.sv]
// Back end: clears video memory after reset, executes writes and renders lines.
// Depends on tsg_pkg, tsg_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tsg_back #(
   parameter int VIDEO_DEPTH = 1024
) (
   input  wire  logic              clock,
   input  wire  logic              reset,
   input  wire  tsg_pkg::qstat_type qstat,
   input  wire  tsg_pkg::cmd_type  head,
   output logic                    pop,
   output logic                    clearing,
   output logic                    rsp_strobe,
   output tsg_pkg::rsp_type        rsp
);
   import tsg_pkg::*;

   localparam int VAW = $clog2(VIDEO_DEPTH);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   logic [1:0]     state_ff, state_in;
   logic [VAW-1:0] clr_ff, clr_in;
   logic [5:0]     col_ff, col_in;
   cmd_type        cur_ff, cur_in;

   logic           p1_valid_ff, p1_valid_in;
   logic           p1_last_ff, p1_last_in;
   logic           p2_valid_ff;
   logic           p2_last_ff;
   logic [7:0]     p2_ch_ff;

   logic           strobe_ff, strobe_in;
   rsp_type        rsp_ff, rsp_in;

   logic           vid_we;
   logic [VAW-1:0] vid_wa;
   logic [7:0]     vid_wd;
   logic [12:0]    cell_sum;
   logic [12:0]    cell_wrap;
   logic [7:0]     vid_rd;
   logic           font_we;
   logic [6:0]     glyph;
   logic [FONT_AW-1:0] font_ra;
   logic [7:0]     font_rd;
   logic           border_emit;
   logic           upper;
   logic           left_on;
   logic           right_on;
   logic [3:0]     semi_code;
   logic [7:0][3:0] pairs;

   // Take a command only once the render pipeline has drained
   assign pop = (state_ff == ST_IDLE) && qstat.not_empty && !p1_valid_ff && !p2_valid_ff;
   assign clearing    = (state_ff == ST_CLEAR);
   assign border_emit = pop && (head.kind == CMD_BORDER);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      col_in      = col_ff;
      cur_in      = cur_ff;
      p1_valid_in = 1'b0;
      p1_last_in  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == VAW'(VIDEO_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop && head.kind == CMD_TEXT) begin
               state_in = ST_RUN;
               cur_in   = head;
               col_in   = 6'd0;
            end
         end
         ST_RUN: begin
            p1_valid_in = 1'b1;
            p1_last_in  = (col_ff == cur_ff.ncols - 6'd1);
            col_in      = col_ff + 6'd1;
            if (p1_last_in) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Video memory: clearing sweep or a write command
   always_comb begin
      vid_we = clearing || (pop && head.kind == CMD_VIDEO);
      vid_wa = clearing ? clr_ff : VAW'(head.address);
      vid_wd = clearing ? 8'd0 : head.data;
   end

   // Cell of the current column, wrapped once at the memory depth
   assign cell_sum  = 13'(cur_ff.base) + 13'(col_ff);
   assign cell_wrap = (cell_sum >= 13'(VIDEO_DEPTH)) ? cell_sum - 13'(VIDEO_DEPTH) : cell_sum;

   tsg_ram #(
      .WIDTH (8),
      .DEPTH (VIDEO_DEPTH)
   ) u_video (
      .clock   (clock),
      .wr_en   (vid_we),
      .wr_addr (vid_wa),
      .wr_data (vid_wd),
      .rd_addr (cell_wrap[VAW-1:0]),
      .rd_data (vid_rd)
   );

   // Font row address from the character code
   assign font_we = pop && (head.kind == CMD_FONT);
   assign glyph   = 7'(vid_rd - FIRST_GLYPH);
   assign font_ra = FONT_AW'({glyph, 3'b000}) + FONT_AW'({glyph, 2'b00})
                  + FONT_AW'(cur_ff.glyph_row);

   tsg_ram #(
      .WIDTH (8),
      .DEPTH (FONT_DEPTH)
   ) u_font (
      .clock   (clock),
      .wr_en   (font_we),
      .wr_addr (head.address[FONT_AW-1:0]),
      .wr_data (head.data),
      .rd_addr (font_ra),
      .rd_data (font_rd)
   );

   // Expand one character into eight pixel pairs
   assign upper     = cur_ff.glyph_row < UPPER_ROWS;
   assign left_on   = upper ? p2_ch_ff[3] : p2_ch_ff[1];
   assign right_on  = upper ? p2_ch_ff[2] : p2_ch_ff[0];
   assign semi_code = {SEMI_FLAG, p2_ch_ff[6:4]};

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         if (p2_ch_ff < FIRST_GLYPH) begin
            pairs[k] = CODE_BG;
         end else if (!p2_ch_ff[7]) begin
            pairs[k] = font_rd[7-k] ? CODE_FG : CODE_BG;
         end else if (k < 4) begin
            pairs[k] = left_on ? semi_code : CODE_BLACK;
         end else begin
            pairs[k] = right_on ? semi_code : CODE_BLACK;
         end
      end
   end

   // Output word: border line or a rendered column
   always_comb begin
      strobe_in = border_emit || p2_valid_ff;
      if (border_emit) begin
         rsp_in.pair      = '0;
         rsp_in.is_border = 1'b1;
         rsp_in.last      = 1'b1;
      end else begin
         rsp_in.pair      = pairs;
         rsp_in.is_border = 1'b0;
         rsp_in.last      = p2_last_ff;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p1_valid_ff;
         strobe_ff   <= strobe_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      col_ff     <= col_in;
      cur_ff     <= cur_in;
      p1_last_ff <= p1_last_in;
      p2_last_ff <= p1_last_ff;
      p2_ch_ff   <= vid_rd;
      if (strobe_in) begin
         rsp_ff <= rsp_in;
      end
   end

   `TSG_ASSERT(a_run_col, clock, reset, (state_ff == ST_RUN) |-> (col_ff < cur_ff.ncols), "column past row end")
   `TSG_ASSERT(a_no_collide, clock, reset, border_emit |-> !p2_valid_ff, "border word collides with column word")
   `TSG_ASSERT(a_clear_quiet, clock, reset, clearing |-> !pop && !p1_valid_ff, "command taken during clear")

endmodule

`default_nettype wire

[src/text_semigraphics_line_renderer.sv]
// Renderer top level: the front end holds one word at a time and takes no new word until
// stage two has pushed its word into the queue or dropped it. The back end takes one command
// per pass: a write or a border line is popped alone, a text line is popped, reads one video
// cell per column, then drains the pipeline before the next pop. Results cannot be stalled.
// Reset is synchronous; afterwards a sweep zeroes every video memory address with busy high.
`default_nettype none

module text_semigraphics_line_renderer #(
   parameter int VIDEO_DEPTH = 1024
) (
   input  wire  logic        clock,
   input  wire  logic        reset,
   // Input words
   input  wire  logic        start,
   output logic              busy,
   input  wire  logic [1:0]  req_operation,
   input  wire  logic [10:0] req_address,
   input  wire  logic [7:0]  req_write_data,
   input  wire  logic [8:0]  req_line_number,
   // Result words
   output logic              rsp_strobe,
   output logic [3:0]        rsp_pair0,
   output logic [3:0]        rsp_pair1,
   output logic [3:0]        rsp_pair2,
   output logic [3:0]        rsp_pair3,
   output logic [3:0]        rsp_pair4,
   output logic [3:0]        rsp_pair5,
   output logic [3:0]        rsp_pair6,
   output logic [3:0]        rsp_pair7,
   output logic              rsp_is_border,
   output logic              rsp_last,
   // Register port
   input  wire  logic        psel,
   input  wire  logic        penable,
   input  wire  logic        pwrite,
   input  wire  logic [2:0]  paddr,
   input  wire  logic [31:0] pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import tsg_pkg::*;

   localparam logic       REG_COLUMNS   = 1'b0;
   localparam logic       REG_ROWS      = 1'b1;
   localparam logic [5:0] COLUMNS_RESET = 6'd32;
   localparam logic [4:0] ROWS_RESET    = 5'd16;

   logic [5:0] columns_ff, columns_in;
   logic [4:0] rows_ff, rows_in;
   logic       csr_write;
   logic       clearing;
   logic       push;
   logic       pop;
   cmd_type    push_cmd;
   cmd_type    head;
   qstat_type  qstat;
   rsp_type    rsp;

   // Register writes
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      columns_in = columns_ff;
      rows_in    = rows_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_COLUMNS: columns_in = pwdata[5:0];
            REG_ROWS:    rows_in    = pwdata[4:0];
            default:     columns_in = columns_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
         rows_ff    <= ROWS_RESET;
      end else begin
         columns_ff <= columns_in;
         rows_ff    <= rows_in;
      end
   end

   // Register reads
   always_comb begin
      unique case (paddr[2])
         REG_COLUMNS: prdata = 32'(columns_ff);
         REG_ROWS:    prdata = 32'(rows_ff);
         default:     prdata = '0;
      endcase
   end

   tsg_front #(
      .VIDEO_DEPTH (VIDEO_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .block       (clearing),
      .busy        (busy),
      .operation   (req_operation),
      .address     (req_address),
      .write_data  (req_write_data),
      .line_number (req_line_number),
      .columns     (columns_ff),
      .rows        (rows_ff),
      .qstat       (qstat),
      .push        (push),
      .cmd         (push_cmd)
   );

   tsg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   tsg_back #(
      .VIDEO_DEPTH (VIDEO_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head       (head),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   // Split the result word onto its ports
   assign rsp_pair0     = rsp.pair[0];
   assign rsp_pair1     = rsp.pair[1];
   assign rsp_pair2     = rsp.pair[2];
   assign rsp_pair3     = rsp.pair[3];
   assign rsp_pair4     = rsp.pair[4];
   assign rsp_pair5     = rsp.pair[5];
   assign rsp_pair6     = rsp.pair[6];
   assign rsp_pair7     = rsp.pair[7];
   assign rsp_is_border = rsp.is_border;
   assign rsp_last      = rsp.last;

endmodule

`default_nettype wire
